// ===== hw/rtl/xif_pkg.sv =====
// Shared types, opcode constants and decode functions for the x86 instruction framer.
// Used by xif_core and by the top level x86_16bit_instruction_framer.
package xif_pkg;

	typedef enum logic [1:0] {
		PH_OPCODE,
		PH_MODRM,
		PH_DISP,
		PH_IMM
	} phase_t;

	// Per-opcode decode: illegal flag, ModRM follows, and immediate byte count.
	typedef struct packed {
		logic       ill;
		logic       modrm;
		logic [2:0] imm;
	} op_class_t;

	// One framed instruction.
	typedef struct packed {
		logic [7:0]  opcode;
		logic        has_modrm;
		logic [7:0]  modrm;
		logic [1:0]  disp_bytes;
		logic [15:0] displacement;
		logic [1:0]  imm_bytes;
		logic [15:0] immediate;
		logic        has_segment;
		logic [15:0] segment_word;
		logic [2:0]  length;
		logic        illegal;
	} frame_rec_t;

	localparam logic [7:0] OP_ESC_0F  = 8'h0F;
	localparam logic [7:0] OP_MOV_RS  = 8'h8C;
	localparam logic [7:0] OP_MOV_SR  = 8'h8E;
	localparam logic [7:0] OP_POP_RM  = 8'h8F;
	localparam logic [7:0] OP_SHF_LO  = 8'hD0;
	localparam logic [7:0] OP_SHF_HI  = 8'hD3;
	localparam logic [7:0] OP_AAM     = 8'hD4;
	localparam logic [7:0] OP_AAD     = 8'hD5;
	localparam logic [7:0] OP_GRP3B   = 8'hF6;
	localparam logic [7:0] OP_GRP3W   = 8'hF7;
	localparam logic [7:0] OP_GRP4    = 8'hFE;
	localparam logic [7:0] OP_GRP5    = 8'hFF;

	localparam logic [15:0] ASCII_BASE = 16'h000A;

	localparam logic [1:0] MOD_MEM    = 2'b00;
	localparam logic [1:0] MOD_DISP8  = 2'b01;
	localparam logic [1:0] MOD_DISP16 = 2'b10;
	localparam logic [2:0] RM_DIRECT  = 3'd6;

	localparam logic [2:0] IMM_NONE = 3'd0;
	localparam logic [2:0] IMM_B    = 3'd1;
	localparam logic [2:0] IMM_W    = 3'd2;
	localparam logic [2:0] IMM_FAR  = 3'd4;

	function automatic op_class_t xif_classify(input logic [7:0] op);
		logic [4:0] g;
		logic [2:0] s;
		op_class_t  c;
		g = op[7:3];
		s = op[2:0];
		c = '{ill: 1'b0, modrm: 1'b0, imm: IMM_NONE};
		unique case (g) inside
			[5'd0:5'd7]: begin
				if (s < 3'd4) c.modrm = 1'b1;
				else if (s == 3'd4) c.imm = IMM_B;
				else if (s == 3'd5) c.imm = IMM_W;
				else c.ill = (op == OP_ESC_0F);
			end
			5'd12, 5'd13: c.ill = 1'b1;
			5'd14, 5'd15, 5'd22, 5'd28: c.imm = IMM_B;
			5'd16: begin
				c.modrm = 1'b1;
				if (s < 3'd4) c.imm = (s == 3'd1) ? IMM_W : IMM_B;
			end
			5'd17, 5'd27: c.modrm = 1'b1;
			5'd19: c.imm = (s == 3'd2) ? IMM_FAR : IMM_NONE;
			5'd20: c.imm = (s < 3'd4) ? IMM_W : IMM_NONE;
			5'd21: begin
				if (s == 3'd0) c.imm = IMM_B;
				else if (s == 3'd1) c.imm = IMM_W;
			end
			5'd23: c.imm = IMM_W;
			5'd24: begin
				if (s < 3'd2) c.ill = 1'b1;
				else if (s == 3'd2) c.imm = IMM_W;
				else if (s == 3'd6) begin
					c.modrm = 1'b1;
					c.imm   = IMM_B;
				end else if (s == 3'd7) begin
					c.modrm = 1'b1;
					c.imm   = IMM_W;
				end else if (s != 3'd3) c.modrm = 1'b1;
			end
			5'd25: begin
				if (s < 3'd2) c.ill = 1'b1;
				else if (s == 3'd2) c.imm = IMM_W;
				else if (s == 3'd5) c.imm = IMM_B;
			end
			5'd26: begin
				if (s < 3'd4) c.modrm = 1'b1;
				else if (s < 3'd6) c.imm = IMM_B;
				else if (s == 3'd6) c.ill = 1'b1;
			end
			5'd29: begin
				if (s < 3'd2) c.imm = IMM_W;
				else if (s == 3'd2) c.imm = IMM_FAR;
				else if (s == 3'd3) c.imm = IMM_B;
			end
			5'd30: begin
				if (s == 3'd1) c.ill = 1'b1;
				else if (s == 3'd6) begin
					c.modrm = 1'b1;
					c.imm   = IMM_B;
				end else if (s == 3'd7) begin
					c.modrm = 1'b1;
					c.imm   = IMM_W;
				end
			end
			5'd31: c.modrm = (s >= 3'd6);
			default: c.ill = 1'b0;
		endcase
		return c;
	endfunction

	// Encodings whose ModRM reg field selects no valid operation.
	function automatic logic xif_modrm_illegal(input logic [7:0] op, input logic [7:0] m);
		logic [2:0] r;
		logic       bad;
		r = m[5:3];
		if (op == OP_MOV_RS || op == OP_MOV_SR) bad = m[5];
		else if (op == OP_POP_RM) bad = (r != 3'd0);
		else if (op >= OP_SHF_LO && op <= OP_SHF_HI) bad = (r == 3'd6);
		else if (op == OP_GRP3B || op == OP_GRP3W) bad = (r == 3'd1);
		else if (op == OP_GRP4) bad = (r > 3'd1);
		else if (op == OP_GRP5) bad = (r == 3'd7);
		else bad = 1'b0;
		return bad;
	endfunction

	// Displacement bytes implied by ModRM mod and rm.
	function automatic logic [1:0] xif_disp_len(input logic [7:0] m);
		logic [1:0] n;
		if (m[7:6] == MOD_DISP8) n = 2'd1;
		else if (m[7:6] == MOD_DISP16) n = 2'd2;
		else if (m[7:6] == MOD_MEM && m[2:0] == RM_DIRECT) n = 2'd2;
		else n = 2'd0;
		return n;
	endfunction

endpackage

// ===== hw/rtl/xif_core.sv =====
// Framing state machine: tracks the phase of the current instruction and collects its bytes.
// Depends on xif_pkg for the phase type, the record type and the decode functions.
module xif_core
	import xif_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  code,
	output logic        emit,
	output frame_rec_t  rec
);

	phase_t      phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [7:0]  modrm_q, modrm_d;
	logic        taken_q, taken_d;
	logic [1:0]  disp_total_q, disp_total_d;
	logic [1:0]  disp_left_q, disp_left_d;
	logic [2:0]  imm_total_q, imm_total_d;
	logic [2:0]  imm_left_q, imm_left_d;
	logic [15:0] disp_word_q, disp_word_d;
	logic [15:0] imm_word_q, imm_word_d;
	logic [15:0] seg_word_q, seg_word_d;
	logic [2:0]  count_q, count_d;
	logic        ill;
	logic        ascii_bad;
	op_class_t   cls;
	logic        dpos;
	logic [1:0]  ipos;

	assign cls  = xif_classify(code);
	assign dpos = 1'(disp_total_q - disp_left_q);
	assign ipos = 2'(imm_total_q - imm_left_q);

	// Next state and collected fields for the byte presented this cycle.
	always_comb begin
		phase_d      = phase_q;
		opcode_d     = opcode_q;
		modrm_d      = modrm_q;
		taken_d      = taken_q;
		disp_total_d = disp_total_q;
		disp_left_d  = disp_left_q;
		imm_total_d  = imm_total_q;
		imm_left_d   = imm_left_q;
		disp_word_d  = disp_word_q;
		imm_word_d   = imm_word_q;
		seg_word_d   = seg_word_q;
		count_d      = count_q + 3'd1;
		emit         = 1'b0;
		ill          = 1'b0;
		unique case (phase_q)
			PH_OPCODE: begin
				opcode_d     = code;
				modrm_d      = 8'd0;
				taken_d      = 1'b0;
				disp_total_d = 2'd0;
				disp_left_d  = 2'd0;
				imm_left_d   = 3'd0;
				disp_word_d  = 16'd0;
				imm_word_d   = 16'd0;
				seg_word_d   = 16'd0;
				count_d      = 3'd1;
				imm_total_d  = cls.imm;
				if (cls.ill) begin
					emit = 1'b1;
					ill  = 1'b1;
				end else if (cls.modrm) begin
					phase_d = PH_MODRM;
				end else if (cls.imm != IMM_NONE) begin
					imm_left_d = cls.imm;
					phase_d    = PH_IMM;
				end else begin
					emit = 1'b1;
				end
			end
			PH_MODRM: begin
				modrm_d = code;
				taken_d = 1'b1;
				if (xif_modrm_illegal(opcode_q, code)) begin
					imm_total_d = IMM_NONE;
					emit        = 1'b1;
					ill         = 1'b1;
				end else begin
					// Only the TEST form of group 3 carries an immediate.
					if ((opcode_q == OP_GRP3B || opcode_q == OP_GRP3W) && code[5:3] != 3'd0)
						imm_total_d = IMM_NONE;
					disp_total_d = xif_disp_len(code);
					disp_left_d  = disp_total_d;
					if (disp_total_d != 2'd0) begin
						phase_d = PH_DISP;
					end else if (imm_total_d != IMM_NONE) begin
						imm_left_d = imm_total_d;
						phase_d    = PH_IMM;
					end else begin
						emit = 1'b1;
					end
				end
			end
			PH_DISP: begin
				if (dpos) disp_word_d[15:8] = code;
				else disp_word_d[7:0] = code;
				disp_left_d = disp_left_q - 2'd1;
				if (disp_left_d == 2'd0) begin
					if (imm_total_q != IMM_NONE) begin
						imm_left_d = imm_total_q;
						phase_d    = PH_IMM;
					end else begin
						emit = 1'b1;
					end
				end
			end
			PH_IMM: begin
				case (ipos)
					2'd0:    imm_word_d[7:0]  = code;
					2'd1:    imm_word_d[15:8] = code;
					2'd2:    seg_word_d[7:0]  = code;
					default: seg_word_d[15:8] = code;
				endcase
				imm_left_d = imm_left_q - 3'd1;
				if (imm_left_d == 3'd0) emit = 1'b1;
			end
			default: phase_d = PH_OPCODE;
		endcase
		if (emit) phase_d = PH_OPCODE;
	end

	// The record of the instruction that this byte completes.
	always_comb begin
		ascii_bad = (opcode_d == OP_AAM || opcode_d == OP_AAD) && (imm_word_d != ASCII_BASE);
		rec.opcode       = opcode_d;
		rec.has_modrm    = taken_d;
		rec.modrm        = taken_d ? modrm_d : 8'd0;
		rec.disp_bytes   = disp_total_d;
		rec.displacement = disp_word_d;
		rec.imm_bytes    = (imm_total_d > IMM_W) ? 2'd2 : imm_total_d[1:0];
		rec.immediate    = imm_word_d;
		rec.has_segment  = (imm_total_d == IMM_FAR);
		rec.segment_word = seg_word_d;
		rec.length       = count_d;
		rec.illegal      = ill | ascii_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OPCODE;
			opcode_q     <= 8'd0;
			modrm_q      <= 8'd0;
			taken_q      <= 1'b0;
			disp_total_q <= 2'd0;
			disp_left_q  <= 2'd0;
			imm_total_q  <= 3'd0;
			imm_left_q   <= 3'd0;
			disp_word_q  <= 16'd0;
			imm_word_q   <= 16'd0;
			seg_word_q   <= 16'd0;
			count_q      <= 3'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			opcode_q     <= opcode_d;
			modrm_q      <= modrm_d;
			taken_q      <= taken_d;
			disp_total_q <= disp_total_d;
			disp_left_q  <= disp_left_d;
			imm_total_q  <= imm_total_d;
			imm_left_q   <= imm_left_d;
			disp_word_q  <= disp_word_d;
			imm_word_q   <= imm_word_d;
			seg_word_q   <= seg_word_d;
			count_q      <= count_d;
		end
	end

	a_disp_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISP |-> disp_left_q != 2'd0 && disp_left_q <= disp_total_q)
		else $error("displacement phase with no bytes left");

	a_imm_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IMM |-> imm_left_q != 3'd0 && imm_left_q <= imm_total_q)
		else $error("immediate phase with no bytes left");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |-> rec.length != 3'd0 && rec.length <= 3'd6)
		else $error("framed instruction length out of range");

	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_OPCODE && !emit |=> phase_q != PH_OPCODE)
		else $error("opcode without a result did not open an instruction");

endmodule

// ===== hw/rtl/x86_16bit_instruction_framer.sv =====
// Top level of the x86 16-bit instruction framer: input register, framing core, result register.
// Depends on xif_pkg and xif_core.
//
// Usage: code bytes enter on in_valid/in_stall with code_byte, one byte per transaction.
// Each completed instruction leaves as one transaction on out_valid/out_stall with
// its fields on separate ports. Bytes that do not end an instruction give no result.
// A byte lands in the input register when it is accepted; from there the core updates
// and, if the instruction is complete, the record is loaded into the result register.
// Throughput: one byte per cycle while in_stall is low, set by the framing step in
// xif_core, which takes the held byte whenever step is high.
// When the receiver stalls, the result register holds its record and the input register
// keeps accepting bytes that complete no instruction; only a byte that would finish
// another instruction waits in the input register, and then in_stall is raised.
// Reset clears the valid flags and returns the core to expecting an opcode.
module x86_16bit_instruction_framer
	import xif_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  opcode,
	output logic        has_modrm,
	output logic [7:0]  modrm,
	output logic [1:0]  disp_bytes,
	output logic [15:0] displacement,
	output logic [1:0]  imm_bytes,
	output logic [15:0] immediate,
	output logic        has_segment,
	output logic [15:0] segment_word,
	output logic [2:0]  length,
	output logic        illegal
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	frame_rec_t rec_s2;
	frame_rec_t rec;
	logic       emit;
	logic       advance;
	logic       step;

	// The held byte may advance unless it finishes an instruction while the result is stuck.
	assign advance  = !emit || !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	xif_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.code   (byte_s1),
		.emit   (emit),
		.rec    (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= code_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && emit) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			rec_s2 <= rec;
		end
	end

	assign out_valid    = valid_s2;
	assign opcode       = rec_s2.opcode;
	assign has_modrm    = rec_s2.has_modrm;
	assign modrm        = rec_s2.modrm;
	assign disp_bytes   = rec_s2.disp_bytes;
	assign displacement = rec_s2.displacement;
	assign imm_bytes    = rec_s2.imm_bytes;
	assign immediate    = rec_s2.immediate;
	assign has_segment  = rec_s2.has_segment;
	assign segment_word = rec_s2.segment_word;
	assign length       = rec_s2.length;
	assign illegal      = rec_s2.illegal;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |-> !(step && emit))
		else $error("pending result overwritten");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(rec_s2))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && emit && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");

endmodule

// ===== test/frame_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the x86 instruction framer. It watches both channels, frames the
// accepted code bytes with its own decoder and compares every record field by field.
// Depends on xif_pkg for the record type, the phase enum and the opcode constants.
module frame_checker
	import xif_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  code_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  opcode,
	input  logic        has_modrm,
	input  logic [7:0]  modrm,
	input  logic [1:0]  disp_bytes,
	input  logic [15:0] displacement,
	input  logic [1:0]  imm_bytes,
	input  logic [15:0] immediate,
	input  logic        has_segment,
	input  logic [15:0] segment_word,
	input  logic [2:0]  length,
	input  logic        illegal,
	output int          mismatches,
	output int          pending,
	output int          frames_checked,
	output int          illegal_frames
);

	phase_t      ph;
	logic [7:0]  op_q;
	logic [7:0]  modrm_q;
	logic        modrm_seen;
	logic [1:0]  disp_total;
	logic [1:0]  disp_left;
	logic [2:0]  imm_total;
	logic [2:0]  imm_left;
	logic [15:0] gathered [3];
	logic [2:0]  nbytes;
	frame_rec_t  expected_frames [$];

	// What the first byte of an instruction implies: illegal, ModRM follows, operand bytes.
	function automatic op_class_t opcode_shape(input logic [7:0] op);
		op_class_t  c;
		logic [2:0] lo;
		c = '0;
		lo = op[2:0];
		case (op[7:3])
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7: begin
				if (!lo[2]) c.modrm = 1'b1;
				else if (lo == 3'd4) c.imm = IMM_B;
				else if (lo == 3'd5) c.imm = IMM_W;
				else c.ill = (op == OP_ESC_0F);
			end
			5'd12, 5'd13: c.ill = 1'b1;
			5'd14, 5'd15, 5'd22, 5'd28: c.imm = IMM_B;
			5'd16: begin
				c.modrm = 1'b1;
				if (!lo[2]) c.imm = (lo == 3'd1) ? IMM_W : IMM_B;
			end
			5'd17, 5'd27: c.modrm = 1'b1;
			5'd19: if (lo == 3'd2) c.imm = IMM_FAR;
			5'd20: if (!lo[2]) c.imm = IMM_W;
			5'd21: begin
				if (lo == 3'd0) c.imm = IMM_B;
				else if (lo == 3'd1) c.imm = IMM_W;
			end
			5'd23: c.imm = IMM_W;
			5'd24: begin
				case (lo)
					3'd0, 3'd1: c.ill = 1'b1;
					3'd2: c.imm = IMM_W;
					3'd3: ;
					3'd6: begin
						c.modrm = 1'b1;
						c.imm = IMM_B;
					end
					3'd7: begin
						c.modrm = 1'b1;
						c.imm = IMM_W;
					end
					default: c.modrm = 1'b1;
				endcase
			end
			5'd25: begin
				case (lo)
					3'd0, 3'd1: c.ill = 1'b1;
					3'd2: c.imm = IMM_W;
					3'd5: c.imm = IMM_B;
					default: ;
				endcase
			end
			5'd26: begin
				if (!lo[2]) c.modrm = 1'b1;
				else if (lo < 3'd6) c.imm = IMM_B;
				else if (lo == 3'd6) c.ill = 1'b1;
			end
			5'd29: begin
				case (lo)
					3'd0, 3'd1: c.imm = IMM_W;
					3'd2: c.imm = IMM_FAR;
					3'd3: c.imm = IMM_B;
					default: ;
				endcase
			end
			5'd30: begin
				case (lo)
					3'd1: c.ill = 1'b1;
					3'd6: begin
						c.modrm = 1'b1;
						c.imm = IMM_B;
					end
					3'd7: begin
						c.modrm = 1'b1;
						c.imm = IMM_W;
					end
					default: ;
				endcase
			end
			5'd31: c.modrm = (lo >= 3'd6);
			default: ;
		endcase
		return c;
	endfunction

	// ModRM reg values that select nothing for the opcodes that use reg as a sub-opcode.
	function automatic logic reg_field_bad(input logic [7:0] op, input logic [7:0] m);
		logic [2:0] r;
		r = m[5:3];
		case (op)
			OP_MOV_RS, OP_MOV_SR: return m[5];
			OP_POP_RM: return r != 3'd0;
			OP_GRP3B, OP_GRP3W: return r == 3'd1;
			OP_GRP4: return r > 3'd1;
			OP_GRP5: return r == 3'd7;
			default: return (op >= OP_SHF_LO && op <= OP_SHF_HI) && r == 3'd6;
		endcase
	endfunction

	task automatic clear_frame();
		ph = PH_OPCODE;
		op_q = '0;
		modrm_q = '0;
		modrm_seen = 1'b0;
		disp_total = '0;
		disp_left = '0;
		imm_total = '0;
		imm_left = '0;
		gathered[0] = '0;
		gathered[1] = '0;
		gathered[2] = '0;
		nbytes = '0;
	endtask

	task automatic close_frame(input logic bad);
		frame_rec_t rec;
		// AAM and AAD are only meaningful with base ten.
		if ((op_q == OP_AAM || op_q == OP_AAD) && !bad && gathered[1] != ASCII_BASE)
			bad = 1'b1;
		rec.opcode = op_q;
		rec.has_modrm = modrm_seen;
		rec.modrm = modrm_seen ? modrm_q : 8'h00;
		rec.disp_bytes = disp_total;
		rec.displacement = gathered[0];
		rec.imm_bytes = (imm_total == IMM_FAR) ? 2'd2 : imm_total[1:0];
		rec.immediate = gathered[1];
		rec.has_segment = (imm_total == IMM_FAR);
		rec.segment_word = gathered[2];
		rec.length = nbytes;
		rec.illegal = bad;
		expected_frames.push_back(rec);
		ph = PH_OPCODE;
	endtask

	task automatic start_operand_or_close();
		if (imm_total != IMM_NONE) begin
			imm_left = imm_total;
			ph = PH_IMM;
		end else begin
			close_frame(1'b0);
		end
	endtask

	task automatic frame_byte(input logic [7:0] b);
		op_class_t  shape;
		logic [2:0] slot;
		case (ph)
			PH_MODRM: begin
				modrm_q = b;
				modrm_seen = 1'b1;
				nbytes = nbytes + 3'd1;
				if (reg_field_bad(op_q, b)) begin
					imm_total = IMM_NONE;
					close_frame(1'b1);
				end else begin
					// Only TEST in group 3 carries an immediate.
					if ((op_q == OP_GRP3B || op_q == OP_GRP3W) && b[5:3] != 3'd0)
						imm_total = IMM_NONE;
					case (b[7:6])
						MOD_DISP8: disp_total = 2'd1;
						MOD_DISP16: disp_total = 2'd2;
						MOD_MEM: disp_total = (b[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
						default: disp_total = 2'd0;
					endcase
					disp_left = disp_total;
					if (disp_left != 2'd0) ph = PH_DISP;
					else start_operand_or_close();
				end
			end
			PH_DISP: begin
				slot = {1'b0, disp_total} - {1'b0, disp_left};
				if (slot[0]) gathered[0][15:8] = b;
				else gathered[0][7:0] = b;
				disp_left = disp_left - 2'd1;
				nbytes = nbytes + 3'd1;
				if (disp_left == 2'd0) start_operand_or_close();
			end
			PH_IMM: begin
				// The third and fourth bytes of a far pointer form the segment word.
				slot = imm_total - imm_left;
				if (slot[0]) gathered[slot[1] ? 2 : 1][15:8] = b;
				else gathered[slot[1] ? 2 : 1][7:0] = b;
				imm_left = imm_left - 3'd1;
				nbytes = nbytes + 3'd1;
				if (imm_left == 3'd0) close_frame(1'b0);
			end
			default: begin
				clear_frame();
				op_q = b;
				nbytes = 3'd1;
				shape = opcode_shape(b);
				imm_total = shape.imm;
				if (shape.ill) close_frame(1'b1);
				else if (shape.modrm) ph = PH_MODRM;
				else start_operand_or_close();
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_rec_t want;
		if (!arst_n) begin
			clear_frame();
			expected_frames.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					report_mismatch("result with no instruction pending, opcode",
						{8'h00, opcode}, 16'h0000);
				end else begin
					want = expected_frames.pop_front();
					check_field("opcode", opcode, want.opcode);
					check_field("has_modrm", has_modrm, want.has_modrm);
					check_field("modrm", modrm, want.modrm);
					check_field("disp_bytes", disp_bytes, want.disp_bytes);
					check_field("displacement", displacement, want.displacement);
					check_field("imm_bytes", imm_bytes, want.imm_bytes);
					check_field("immediate", immediate, want.immediate);
					check_field("has_segment", has_segment, want.has_segment);
					check_field("segment_word", segment_word, want.segment_word);
					check_field("length", length, want.length);
					check_field("illegal", illegal, want.illegal);
					frames_checked++;
					if (want.illegal) illegal_frames++;
				end
			end
			if (in_valid && !in_stall) frame_byte(code_byte);
			pending = expected_frames.size();
		end
	end

endmodule

// ===== test/x86_16bit_instruction_framer_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the x86 instruction framer: clock, reset, code byte stimulus,
// result receiver with random and long hold-offs, watchdog and verdict.
// Depends on x86_16bit_instruction_framer and frame_checker.
module x86_16bit_instruction_framer_test;

	localparam int TOTAL_BYTES = 850;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  code_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [7:0]  opcode;
	logic        has_modrm;
	logic [7:0]  modrm;
	logic [1:0]  disp_bytes;
	logic [15:0] displacement;
	logic [1:0]  imm_bytes;
	logic [15:0] immediate;
	logic        has_segment;
	logic [15:0] segment_word;
	logic [2:0]  length;
	logic        illegal;

	int         mismatches;
	int         pending;
	int         frames_checked;
	int         illegal_frames;
	int         bytes_sent = 0;
	int         frames_taken = 0;
	int         idle_cycles = 0;
	bit         held_off = 1'b0;
	logic [7:0] opening [$];
	logic [7:0] hot_bytes [$];

	always #5 clk = ~clk;

	x86_16bit_instruction_framer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.opcode(opcode),
		.has_modrm(has_modrm),
		.modrm(modrm),
		.disp_bytes(disp_bytes),
		.displacement(displacement),
		.imm_bytes(imm_bytes),
		.immediate(immediate),
		.has_segment(has_segment),
		.segment_word(segment_word),
		.length(length),
		.illegal(illegal)
	);

	frame_checker framer_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.opcode(opcode),
		.has_modrm(has_modrm),
		.modrm(modrm),
		.disp_bytes(disp_bytes),
		.displacement(displacement),
		.imm_bytes(imm_bytes),
		.immediate(immediate),
		.has_segment(has_segment),
		.segment_word(segment_word),
		.length(length),
		.illegal(illegal),
		.mismatches(mismatches),
		.pending(pending),
		.frames_checked(frames_checked),
		.illegal_frames(illegal_frames)
	);

	// One code byte per transaction; every third block of 100 bytes is sent back to back.
	task automatic send_code(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, 15);
		if ((bytes_sent / 100) % 3 == 1) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	initial begin : receiver
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, 15);
			if ((frames_taken / 64) % 3 == 2) gap = 0;
			// One long hold-off lets the framer fill up and push back on its input.
			if (frames_taken == HOLD_AT && !held_off) begin
				gap = HOLD_CYCLES;
				held_off = 1'b1;
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			frames_taken++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		opening = '{
			8'h0F,                              // illegal two-byte escape
			8'hC7, 8'h86, 8'h34, 8'h12, 8'h78, 8'h56, // disp16 plus imm16, six bytes
			8'h9A, 8'h11, 8'h22, 8'h33, 8'h44,        // far call with segment
			8'hD4, 8'h0A,                       // AAM with base ten
			8'hD5, 8'h07,                       // AAD with another base is illegal
			8'hF7, 8'hC8,                       // group 3 reg 1 is illegal
			8'h8E, 8'h26,                       // segment move with bit 5 set
			8'h8B, 8'h06, 8'hFE, 8'hFF,         // direct address form
			8'hF6, 8'hD8,                       // group 3 without immediate
			8'hAA                               // string op, no immediate
		};
		// Opcodes with sub-opcode or operand quirks, plus ModRM and operand corner values.
		hot_bytes = '{
			8'h8C, 8'h8E, 8'h8F, 8'hD0, 8'hD3, 8'hD4, 8'hD5, 8'hF6, 8'hF7, 8'hFE,
			8'hFF, 8'h9A, 8'hEA, 8'hC6, 8'hC7, 8'h80, 8'h81, 8'h83, 8'h0A, 8'h06,
			8'h46, 8'h86, 8'hC0, 8'h3E, 8'h0F, 8'hAA, 8'hA0, 8'hA9, 8'hCD, 8'hE8,
			8'h00, 8'hD6
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[k]) send_code(opening[k]);
		while (bytes_sent < TOTAL_BYTES) begin
			if ($urandom_range(0, 9) < 7)
				send_code(hot_bytes[$urandom_range(0, hot_bytes.size() - 1)]);
			else
				send_code(8'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d code bytes; %0d instructions framed and checked, %0d illegal.",
			bytes_sent, frames_checked, illegal_frames);
		$display("Receiver held results back for %0d cycles once; %0d mismatches found.",
			held_off ? HOLD_CYCLES : 0, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
